// ----- hw/rtl/tpms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-track pair mass selector package
// Shared widths, fixed-point constants, register codes and pipeline types.
// ----------------------------------------------------------------------------
package tpms_pkg;

	// Field widths.
	localparam int P_W     = 24;
	localparam int ANGLE_W = 16;
	localparam int COS_W   = 17;
	localparam int MASS_W  = 24;
	localparam int TAG_W   = 3;
	localparam int BIN_W   = 9;

	// Squared momentum (one track, with mass term) and squared pair sum.
	localparam int P2_W = 48;
	localparam int S2_W = 50;
	// Energy root and mass root widths.
	localparam int E_W  = (P2_W + 1) / 2;
	localparam int MR_W = (S2_W + 1) / 2;

	// Masses in units of 2^-16 GeV, squares in 2^-32 GeV^2.
	localparam int KAON_MASS_FX = 32354;
	localparam int PION_MASS_FX = 9147;
	localparam logic [P2_W-1:0] KAON_M2 = P2_W'(KAON_MASS_FX * KAON_MASS_FX);
	localparam logic [P2_W-1:0] PION_M2 = P2_W'(PION_MASS_FX * PION_MASS_FX);

	localparam int MASS_BINS_DEF = 320;
	localparam int SQRT_STEPS    = 3;
	localparam int DIV_STEPS     = 2;

	// Register map, index = paddr[4:2].
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_ANGLE_MAX = 3'd0;
	localparam logic [2:0] REG_COS_MIN   = 3'd1;
	localparam logic [2:0] REG_COS_MAX   = 3'd2;
	localparam logic [2:0] REG_MASS_MIN  = 3'd3;
	localparam logic [2:0] REG_MASS_MAX  = 3'd4;
	localparam logic [2:0] REG_KAON_TAG  = 3'd5;
	localparam logic [2:0] REG_PION_TAG  = 3'd6;

	// Charge codes in flags[3:2].
	localparam logic [1:0] CHG_PLUS  = 2'd1;
	localparam logic [1:0] CHG_MINUS = 2'd2;

	typedef struct packed {
		logic       valid;
		logic       sel_ok;
		logic [3:0] mask;
	} meta_t;

	typedef struct packed {
		logic [MASS_W-1:0] mass;
		logic              under;
		logic              over;
	} bin_side_t;

endpackage
`default_nettype wire

// ----- hw/rtl/two_track_pair_mass_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-track pair mass selector
// Selects candidate track pairs and computes the kaon-pion invariant mass
// for both mass assignments, with histogram bins and a fill mask.
//
//   Channel   Kind              Width  Contents
//   s_*       stream in         200    one candidate pair per transaction
//   m_*       stream out        72     one result per transaction
//   p*        register access   32     seven selection registers
//
// One pair enters per cycle unless the output stalls. The path is stages
// 1 to 3, energy roots, stages 4 to 6, mass roots, stages 7 and 8, bin
// divider, output register. All stages advance together; a stalled output
// holds the whole pipeline, so s_tready follows m_tready while a result
// waits. Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module two_track_pair_mass_selector
	import tpms_pkg::*;
#(
	parameter int MASS_BINS = MASS_BINS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// px_first[23:0], py_first, pz_first, px_second, py_second, pz_second,
	// angle_first[15:0], angle_second, flags_first[3:0], flags_second,
	// pid_first[5:0], pid_second, zero pad
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [199:0]       s_tdata,
	// passed, fill_mask[3:0], mass_nominal[23:0], mass_swapped[23:0],
	// bin_nominal[8:0], bin_swapped[8:0], zero pad
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [71:0]        m_tdata,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	localparam int BW     = $clog2(MASS_BINS + 1);
	localparam int BINW   = BW + 1;
	localparam int NUM_W  = MASS_W + BW;
	localparam int LE     = (E_W + SQRT_STEPS - 1) / SQRT_STEPS;
	localparam int LM     = (MR_W + SQRT_STEPS - 1) / SQRT_STEPS;
	localparam int LD     = (BW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LC     = 3;
	localparam int D_META = LE + 3 + LM + 2 + LD;

	// ---------------- configuration ----------------
	logic [ANGLE_W-1:0] angle_max_q;
	logic [COS_W-1:0]   cos_min_q, cos_max_q;
	logic [MASS_W-1:0]  mass_min_q, mass_max_q;
	logic [TAG_W-1:0]   kaon_tag_q, pion_tag_q;
	logic [2:0]         reg_idx;
	logic               reg_wr;

	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_max_q <= ANGLE_W'(655);
			cos_min_q   <= COS_W'(9830);
			cos_max_q   <= COS_W'(44237);
			mass_min_q  <= MASS_W'(45875);
			mass_max_q  <= MASS_W'(72090);
			kaon_tag_q  <= TAG_W'(2);
			pion_tag_q  <= TAG_W'(2);
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_ANGLE_MAX: angle_max_q <= pwdata[ANGLE_W-1:0];
				REG_COS_MIN:   cos_min_q   <= pwdata[COS_W-1:0];
				REG_COS_MAX:   cos_max_q   <= pwdata[COS_W-1:0];
				REG_MASS_MIN:  mass_min_q  <= pwdata[MASS_W-1:0];
				REG_MASS_MAX:  mass_max_q  <= pwdata[MASS_W-1:0];
				REG_KAON_TAG:  kaon_tag_q  <= pwdata[TAG_W-1:0];
				REG_PION_TAG:  pion_tag_q  <= pwdata[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ANGLE_MAX: prdata = 32'(angle_max_q);
			REG_COS_MIN:   prdata = 32'(cos_min_q);
			REG_COS_MAX:   prdata = 32'(cos_max_q);
			REG_MASS_MIN:  prdata = 32'(mass_min_q);
			REG_MASS_MAX:  prdata = 32'(mass_max_q);
			REG_KAON_TAG:  prdata = 32'(kaon_tag_q);
			REG_PION_TAG:  prdata = 32'(pion_tag_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- stall control ----------------
	logic en;
	logic valid_s9;

	assign en       = ~valid_s9 | m_tready;
	assign s_tready = en;

	// ---------------- input unpacking ----------------
	logic signed [P_W-1:0] pa_in [3];
	logic signed [P_W-1:0] pb_in [3];
	logic [ANGLE_W-1:0]    angle_first, angle_second;
	logic [3:0]            flags_first, flags_second;
	logic [5:0]            pid_first, pid_second;

	assign pa_in[0]     = s_tdata[23:0];
	assign pa_in[1]     = s_tdata[47:24];
	assign pa_in[2]     = s_tdata[71:48];
	assign pb_in[0]     = s_tdata[95:72];
	assign pb_in[1]     = s_tdata[119:96];
	assign pb_in[2]     = s_tdata[143:120];
	assign angle_first  = s_tdata[159:144];
	assign angle_second = s_tdata[175:160];
	assign flags_first  = s_tdata[179:176];
	assign flags_second = s_tdata[183:180];
	assign pid_first    = s_tdata[189:184];
	assign pid_second   = s_tdata[195:190];

	logic       trk_ok, chg_ok, kt1, kt2, pt1, pt2;
	logic [3:0] mask_in;

	assign trk_ok = flags_first[0] & flags_first[1] & (angle_first < angle_max_q)
		& flags_second[0] & flags_second[1] & (angle_second < angle_max_q);
	assign chg_ok = ((flags_first[3:2] == CHG_PLUS) && (flags_second[3:2] == CHG_MINUS))
		|| ((flags_first[3:2] == CHG_MINUS) && (flags_second[3:2] == CHG_PLUS));
	assign kt1     = pid_first[2:0] >= kaon_tag_q;
	assign kt2     = pid_second[2:0] >= kaon_tag_q;
	assign pt1     = pid_first[5:3] >= pion_tag_q;
	assign pt2     = pid_second[5:3] >= pion_tag_q;
	assign mask_in = {kt2 & pt1, kt1 & pt2, kt2, kt1};

	// ---------------- stage 1: capture and pair sums ----------------
	meta_t                 meta_s1, meta_s2, meta_s3;
	logic signed [P_W-1:0] pa_s1 [3];
	logic signed [P_W-1:0] pb_s1 [3];
	logic signed [P_W:0]   ps_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (en) begin
			meta_s1 <= '{valid: s_tvalid, sel_ok: trk_ok & chg_ok, mask: mask_in};
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pa_s1[i] <= pa_in[i];
				pb_s1[i] <= pb_in[i];
				ps_s1[i] <= {pa_in[i][P_W-1], pa_in[i]} + {pb_in[i][P_W-1], pb_in[i]};
			end
		end
	end

	// ---------------- stage 2: squares ----------------
	logic [P_W-1:0]    mag_a [3];
	logic [P_W-1:0]    mag_b [3];
	logic [P_W:0]      mag_s [3];
	logic [2*P_W-2:0]  sqa_s2 [3];
	logic [2*P_W-2:0]  sqb_s2 [3];
	logic [2*P_W:0]    sqs_s2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_a[i] = pa_s1[i][P_W-1] ? P_W'(-pa_s1[i]) : P_W'(pa_s1[i]);
			mag_b[i] = pb_s1[i][P_W-1] ? P_W'(-pb_s1[i]) : P_W'(pb_s1[i]);
			mag_s[i] = ps_s1[i][P_W]   ? (P_W+1)'(-ps_s1[i]) : (P_W+1)'(ps_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqa_s2[i] <= (2*P_W-1)'(mag_a[i]) * (2*P_W-1)'(mag_a[i]);
				sqb_s2[i] <= (2*P_W-1)'(mag_b[i]) * (2*P_W-1)'(mag_b[i]);
				sqs_s2[i] <= (2*P_W+1)'(mag_s[i]) * (2*P_W+1)'(mag_s[i]);
			end
		end
	end

	// ---------------- stage 3: magnitudes and energy radicands ----------------
	logic [P2_W-1:0] p2a_s3, p2b_s3, z2a_s3, z2b_s3;
	logic [P2_W-1:0] eka_in_s3, epa_in_s3, ekb_in_s3, epb_in_s3;
	logic [S2_W-1:0] s2_s3;
	logic [P2_W-1:0] p2a_c, p2b_c;

	assign p2a_c = P2_W'(sqa_s2[0]) + P2_W'(sqa_s2[1]) + P2_W'(sqa_s2[2]);
	assign p2b_c = P2_W'(sqb_s2[0]) + P2_W'(sqb_s2[1]) + P2_W'(sqb_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			p2a_s3    <= p2a_c;
			p2b_s3    <= p2b_c;
			z2a_s3    <= P2_W'(sqa_s2[2]);
			z2b_s3    <= P2_W'(sqb_s2[2]);
			eka_in_s3 <= p2a_c + KAON_M2;
			epa_in_s3 <= p2a_c + PION_M2;
			ekb_in_s3 <= p2b_c + KAON_M2;
			epb_in_s3 <= p2b_c + PION_M2;
			s2_s3     <= S2_W'(sqs_s2[0]) + S2_W'(sqs_s2[1]) + S2_W'(sqs_s2[2]);
		end
	end

	// ---------------- acceptance ----------------
	logic cos_a, cos_b;

	tpms_cos_check u_cos_a (
		.clk(clk), .en(en), .p2(p2a_s3), .z2(z2a_s3),
		.cos_min(cos_min_q), .cos_max(cos_max_q), .ok(cos_a)
	);

	tpms_cos_check u_cos_b (
		.clk(clk), .en(en), .p2(p2b_s3), .z2(z2b_s3),
		.cos_min(cos_min_q), .cos_max(cos_max_q), .ok(cos_b)
	);

	logic [1:0] cos_d;

	tpms_delay #(.W(2), .DEPTH(D_META - LC)) u_cos_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d({cos_b, cos_a}), .q(cos_d)
	);

	meta_t meta_d;

	tpms_delay #(.W($bits(meta_t)), .DEPTH(D_META)) u_meta_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d(meta_s3), .q(meta_d)
	);

	// ---------------- energies ----------------
	logic [E_W-1:0] eka, epa, ekb, epb;

	tpms_isqrt #(.IN_W(P2_W), .STEPS(SQRT_STEPS)) u_sqrt_ka (
		.clk(clk), .en(en), .v(eka_in_s3), .root(eka)
	);
	tpms_isqrt #(.IN_W(P2_W), .STEPS(SQRT_STEPS)) u_sqrt_pa (
		.clk(clk), .en(en), .v(epa_in_s3), .root(epa)
	);
	tpms_isqrt #(.IN_W(P2_W), .STEPS(SQRT_STEPS)) u_sqrt_kb (
		.clk(clk), .en(en), .v(ekb_in_s3), .root(ekb)
	);
	tpms_isqrt #(.IN_W(P2_W), .STEPS(SQRT_STEPS)) u_sqrt_pb (
		.clk(clk), .en(en), .v(epb_in_s3), .root(epb)
	);

	logic [S2_W-1:0] s2_d;

	tpms_delay #(.W(S2_W), .DEPTH(LE)) u_s2_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d(s2_s3), .q(s2_d)
	);

	// ---------------- stages 4 to 6: mass radicand ----------------
	logic [E_W:0]    enom_s4, esw_s4;
	logic [S2_W-1:0] s2_s4, s2_s5;
	logic [S2_W-1:0] esqn_s5, esqs_s5;
	logic [S2_W-1:0] dn_s6, ds_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			enom_s4 <= (E_W+1)'(eka) + (E_W+1)'(epb);
			esw_s4  <= (E_W+1)'(ekb) + (E_W+1)'(epa);
			s2_s4   <= s2_d;

			esqn_s5 <= S2_W'(enom_s4) * S2_W'(enom_s4);
			esqs_s5 <= S2_W'(esw_s4) * S2_W'(esw_s4);
			s2_s5   <= s2_s4;

			// Not positive gives a mass of zero.
			dn_s6   <= (esqn_s5 > s2_s5) ? esqn_s5 - s2_s5 : '0;
			ds_s6   <= (esqs_s5 > s2_s5) ? esqs_s5 - s2_s5 : '0;
		end
	end

	// ---------------- masses ----------------
	logic [MR_W-1:0] mrn, mrs;

	tpms_isqrt #(.IN_W(S2_W), .STEPS(SQRT_STEPS)) u_sqrt_mn (
		.clk(clk), .en(en), .v(dn_s6), .root(mrn)
	);
	tpms_isqrt #(.IN_W(S2_W), .STEPS(SQRT_STEPS)) u_sqrt_ms (
		.clk(clk), .en(en), .v(ds_s6), .root(mrs)
	);

	// ---------------- stages 7 and 8: bin setup ----------------
	logic [MASS_W-1:0] satn, sats;
	bin_side_t         sn_s7, ss_s7, sn_s8, ss_s8;
	logic [MASS_W-1:0] offn_s7, offs_s7;
	logic [NUM_W-1:0]  numn_s8, nums_s8;
	logic [MASS_W-1:0] den_s8;

	assign satn = (mrn > MR_W'({MASS_W{1'b1}})) ? '1 : MASS_W'(mrn);
	assign sats = (mrs > MR_W'({MASS_W{1'b1}})) ? '1 : MASS_W'(mrs);

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s7   <= '{mass: satn, under: satn < mass_min_q, over: satn >= mass_max_q};
			ss_s7   <= '{mass: sats, under: sats < mass_min_q, over: sats >= mass_max_q};
			offn_s7 <= satn - mass_min_q;
			offs_s7 <= sats - mass_min_q;

			sn_s8   <= sn_s7;
			ss_s8   <= ss_s7;
			numn_s8 <= NUM_W'(offn_s7) * NUM_W'(MASS_BINS);
			nums_s8 <= NUM_W'(offs_s7) * NUM_W'(MASS_BINS);
			den_s8  <= mass_max_q - mass_min_q;
		end
	end

	logic [BW-1:0] qn, qs;

	tpms_div #(.NUM_W(NUM_W), .DEN_W(MASS_W), .Q_W(BW), .STEPS(DIV_STEPS)) u_div_n (
		.clk(clk), .en(en), .num(numn_s8), .den(den_s8), .quo(qn)
	);
	tpms_div #(.NUM_W(NUM_W), .DEN_W(MASS_W), .Q_W(BW), .STEPS(DIV_STEPS)) u_div_s (
		.clk(clk), .en(en), .num(nums_s8), .den(den_s8), .quo(qs)
	);

	bin_side_t sn_d, ss_d;

	tpms_delay #(.W(2 * $bits(bin_side_t)), .DEPTH(LD)) u_side_dly (
		.clk(clk), .arst_n(arst_n), .en(en), .d({ss_s8, sn_s8}), .q({ss_d, sn_d})
	);

	// ---------------- stage 9: output register ----------------
	logic [BINW-1:0]   binn_c, bins_c;
	logic              pass_c;
	logic              passed_s9;
	logic [3:0]        mask_s9;
	logic [MASS_W-1:0] massn_s9, masss_s9;
	logic [BIN_W-1:0]  binn_s9, bins_s9;

	assign pass_c = meta_d.sel_ok & cos_d[0] & cos_d[1];
	assign binn_c = sn_d.under ? '0 : sn_d.over ? BINW'(MASS_BINS + 1) : BINW'(qn) + 1'b1;
	assign bins_c = ss_d.under ? '0 : ss_d.over ? BINW'(MASS_BINS + 1) : BINW'(qs) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= meta_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			passed_s9 <= pass_c;
			mask_s9   <= pass_c ? meta_d.mask : '0;
			massn_s9  <= pass_c ? sn_d.mass : '0;
			masss_s9  <= pass_c ? ss_d.mass : '0;
			binn_s9   <= pass_c ? BIN_W'(binn_c) : '0;
			bins_s9   <= pass_c ? BIN_W'(bins_c) : '0;
		end
	end

	assign m_tvalid = valid_s9;
	assign m_tdata  = {1'b0, bins_s9, binn_s9, masss_s9, massn_s9, mask_s9, passed_s9};

endmodule
`default_nettype wire

// ----- hw/rtl/tpms_delay.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipeline delay line
// Carries side data alongside multi-stage units; advances on enable.
// ----------------------------------------------------------------------------
module tpms_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) pipe_q[i] <= '0;
		end else if (en) begin
			pipe_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) pipe_q[i] <= pipe_q[i-1];
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule
`default_nettype wire

// ----- hw/rtl/tpms_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, STEPS result bits resolved per register stage.
// ----------------------------------------------------------------------------
module tpms_isqrt
	import tpms_pkg::*;
#(
	parameter int IN_W  = 48,
	parameter int STEPS = SQRT_STEPS
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [IN_W-1:0]         v,
	output logic      [(IN_W+1)/2-1:0]   root
);

	localparam int OUT_W = (IN_W + 1) / 2;
	localparam int NS    = (OUT_W + STEPS - 1) / STEPS;
	localparam int RW    = IN_W + 2;

	logic [RW-1:0]    rem_w  [NS+1];
	logic [OUT_W-1:0] root_w [NS+1];

	assign rem_w[0]  = RW'(v);
	assign root_w[0] = '0;

	for (genvar s = 0; s < NS; s++) begin : g_st
		logic [RW-1:0]    rem_c;
		logic [OUT_W-1:0] root_c;
		logic [RW-1:0]    rem_q;
		logic [OUT_W-1:0] root_q;

		// The remainder holds v - root^2; adding bit b to the root costs
		// root * 2^(b+1) + 2^(2b).
		always_comb begin
			logic [RW-1:0] trial;
			int            b;
			trial  = '0;
			b      = 0;
			rem_c  = rem_w[s];
			root_c = root_w[s];
			for (int k = 0; k < STEPS; k++) begin
				b = OUT_W - 1 - (s * STEPS + k);
				if (b >= 0) begin
					trial = (RW'(root_c) << (b + 1)) | (RW'(1) << (2 * b));
					if (rem_c >= trial) begin
						rem_c  = rem_c - trial;
						root_c = root_c | (OUT_W'(1) << b);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q  <= rem_c;
				root_q <= root_c;
			end
		end

		assign rem_w[s+1]  = rem_q;
		assign root_w[s+1] = root_q;
	end

	assign root = root_w[NS];

endmodule
`default_nettype wire

// ----- hw/rtl/tpms_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Quotient of Q_W bits, STEPS bits per stage; the caller keeps
// num below den * 2^Q_W.
// ----------------------------------------------------------------------------
module tpms_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 24,
	parameter int Q_W   = 9,
	parameter int STEPS = 2
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo
);

	localparam int NS = (Q_W + STEPS - 1) / STEPS;
	localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [RW-1:0]    rem_w [NS+1];
	logic [Q_W-1:0]   quo_w [NS+1];
	logic [DEN_W-1:0] den_w [NS+1];

	assign rem_w[0] = RW'(num);
	assign quo_w[0] = '0;
	assign den_w[0] = den;

	for (genvar s = 0; s < NS; s++) begin : g_st
		logic [RW-1:0]    rem_c;
		logic [Q_W-1:0]   quo_c;
		logic [RW-1:0]    rem_q;
		logic [Q_W-1:0]   quo_q;
		logic [DEN_W-1:0] den_q;

		always_comb begin
			logic [RW-1:0] trial;
			int            b;
			trial = '0;
			b     = 0;
			rem_c = rem_w[s];
			quo_c = quo_w[s];
			for (int k = 0; k < STEPS; k++) begin
				b = Q_W - 1 - (s * STEPS + k);
				if (b >= 0) begin
					trial = RW'(den_w[s]) << b;
					if (rem_c >= trial) begin
						rem_c = rem_c - trial;
						quo_c = quo_c | (Q_W'(1) << b);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q <= rem_c;
				quo_q <= quo_c;
				den_q <= den_w[s];
			end
		end

		assign rem_w[s+1] = rem_q;
		assign quo_w[s+1] = quo_q;
		assign den_w[s+1] = den_q;
	end

	assign quo = quo_w[NS];

endmodule
`default_nettype wire

// ----- hw/rtl/tpms_cos_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polar acceptance check
// Exact test cos_min^2 * |p|^2 <= pz^2 * 2^32 <= cos_max^2 * |p|^2 in three
// stages: c * |p|^2, then c * (c * |p|^2), then the compares.
// ----------------------------------------------------------------------------
module tpms_cos_check
	import tpms_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [P2_W-1:0]   p2,
	input  wire logic [P2_W-1:0]   z2,
	input  wire logic [COS_W-1:0]  cos_min,
	input  wire logic [COS_W-1:0]  cos_max,
	output logic                   ok
);

	localparam int T_W = COS_W + P2_W;
	localparam int U_W = 2 * COS_W + P2_W;

	logic [T_W-1:0]  tmin_s1, tmax_s1;
	logic [P2_W-1:0] z2_s1, z2_s2;
	logic            nz_s1, nz_s2, ok_s3;
	logic [U_W-1:0]  umin_s2, umax_s2;
	logic [U_W-1:0]  lhs;

	assign lhs = U_W'({z2_s2, 32'd0});

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s1 <= T_W'(cos_min) * T_W'(p2);
			tmax_s1 <= T_W'(cos_max) * T_W'(p2);
			z2_s1   <= z2;
			nz_s1   <= |p2;

			umin_s2 <= U_W'(cos_min) * U_W'(tmin_s1);
			umax_s2 <= U_W'(cos_max) * U_W'(tmax_s1);
			z2_s2   <= z2_s1;
			nz_s2   <= nz_s1;

			// A track with zero momentum never passes.
			ok_s3   <= nz_s2 && (lhs >= umin_s2) && (lhs <= umax_s2);
		end
	end

	assign ok = ok_s3;

endmodule
`default_nettype wire
